// ===== rtl/core/kcsn_pkg.sv =====
`timescale 1ns / 1ps

package kcsn_pkg;

  localparam int unsigned NumKeys   = 8;
  localparam int unsigned KeyIdxW   = 3;
  localparam int unsigned NoteW     = 7;
  localparam int unsigned VelW      = 7;
  localparam int unsigned ScaleW    = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 7;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgBaseNote    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScaleSelect = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgVelocity    = 2'd2;

  // Reset values of the registers
  localparam logic [NoteW-1:0]  BaseNoteReset    = 7'd48;
  localparam logic [ScaleW-1:0] ScaleSelectReset = 3'd3;
  localparam logic [VelW-1:0]   VelocityReset    = 7'd127;

  localparam logic [NoteW-1:0] NoteMax = 7'd127;

  typedef logic [NumKeys-1:0] key_map_t;

  // Fixed scale masks; bit 7 widens every step, lower bits add one step each
  function automatic key_map_t scale_mask(input logic [ScaleW-1:0] idx);
    key_map_t m;
    case (idx)
      3'd0:    m = 8'h94;
      3'd1:    m = 8'h6E;
      3'd2:    m = 8'h5B;
      3'd3:    m = 8'h6D;
      3'd4:    m = 8'h3B;
      3'd5:    m = 8'h6C;
      3'd6:    m = 8'h76;
      default: m = 8'h5E;
    endcase
    return m;
  endfunction

  // Note for key k: base + k*(1+wide) + count of mask bits below k, saturated; select 0 gives base + k
  function automatic logic [NoteW-1:0] map_note(input logic [NoteW-1:0]   base,
                                                input logic [ScaleW-1:0]  sel,
                                                input logic [KeyIdxW-1:0] key);
    key_map_t   m;
    key_map_t   below;
    logic [4:0] steps;
    logic [7:0] sum;
    m     = scale_mask(sel - 3'd1);
    below = (8'd1 << key) - 8'd1;
    steps = 5'd0;
    if (sel == 3'd0) begin
      steps = {2'b00, key};
    end else begin
      steps = {1'b0, key, 1'b0} >> (~m[7]);
      for (int i = 0; i < NumKeys - 1; i++) begin
        steps = steps + {4'd0, m[i] & below[i]};
      end
    end
    sum = {1'b0, base} + {3'd0, steps};
    return sum[7] ? NoteMax : sum[NoteW-1:0];
  endfunction

endpackage

// ===== rtl/core/key_change_to_scale_notes_unit.sv =====
`timescale 1ns / 1ps

// Key scan to note events. Each accepted scan is compared with the previous
// one; every changed key yields one event, from key 7 down to key 0, and the
// final event of a scan carries last_event. Events leave one per cycle from a
// single output register when out_ready_i does not hold them back; a scan
// with no change gives no event. The next scan is taken in the cycle the
// last pending event is loaded into the output register. Note mapping uses
// the registers as they stand while the events are formed; write them only
// while the unit is idle.
module key_change_to_scale_notes_unit
  import kcsn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [NumKeys-1:0]  key_bits_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                is_note_on_o,
  output logic [NoteW-1:0]    note_number_o,
  output logic [VelW-1:0]     note_velocity_o,
  output logic                last_event_o
);

  logic [NoteW-1:0]  base_note_q;
  logic [ScaleW-1:0] scale_select_q;
  logic [VelW-1:0]   velocity_q;

  key_map_t prev_q;
  key_map_t keys_q;
  key_map_t pend_q, pend_d;

  logic             out_valid_q;
  logic             is_note_on_q;
  logic [NoteW-1:0] note_number_q;
  logic [VelW-1:0]  note_velocity_q;
  logic             last_event_q;

  logic               advance;
  logic               accept;
  logic [KeyIdxW-1:0] sel;
  key_map_t           pend_left;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_note_q    <= BaseNoteReset;
      scale_select_q <= ScaleSelectReset;
      velocity_q     <= VelocityReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBaseNote:    base_note_q    <= cfg_data_i[NoteW-1:0];
        CfgScaleSelect: scale_select_q <= cfg_data_i[ScaleW-1:0];
        CfgVelocity:    velocity_q     <= cfg_data_i[VelW-1:0];
        default: ;
      endcase
    end
  end

  // Pick the highest pending key
  always_comb begin
    sel = '0;
    for (int k = 0; k < NumKeys; k++) begin
      if (pend_q[k]) begin
        sel = KeyIdxW'(k);
      end
    end
  end

  assign pend_left = pend_q & ~(key_map_t'(1) << sel);
  assign advance   = (pend_q != '0) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (pend_q == '0) || (advance && (pend_left == '0));
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    pend_d = pend_q;
    if (advance) begin
      pend_d = pend_left;
    end
    if (accept) begin
      pend_d = key_bits_i ^ prev_q;
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (accept) begin
        prev_q <= key_bits_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      keys_q <= key_bits_i;
    end
  end

  // Output register: load one item per advance, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      is_note_on_q    <= keys_q[sel];
      note_number_q   <= map_note(base_note_q, scale_select_q, sel);
      note_velocity_q <= keys_q[sel] ? velocity_q : '0;
      last_event_q    <= (pend_left == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_note_on_o    = is_note_on_q;
  assign note_number_o   = note_number_q;
  assign note_velocity_o = note_velocity_q;
  assign last_event_o    = last_event_q;

endmodule
